[src/wfe_pkg.sv]
package wfe_pkg;

    // frame geometry
    localparam int PIXELS         = 16;
    localparam int STORE_DEPTH    = PIXELS + 1;
    localparam int BITS_PER_PIXEL = 24;
    localparam int PIXEL_SLOTS    = STORE_DEPTH * BITS_PER_PIXEL;

    // field and counter widths
    localparam int COLOR_W   = 8;
    localparam int GRB_W     = 3 * COLOR_W;
    localparam int LED_IDX_W = 5;
    localparam int PIX_W     = $clog2(STORE_DEPTH);
    localparam int BIT_W     = $clog2(BITS_PER_PIXEL);
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = $clog2(PIXEL_SLOTS + (1 << CFG_W));
    localparam int PROD_W    = 2 * COLOR_W;

    // register reset values
    localparam logic [CFG_W-1:0] DUTY_HIGH_RST = 8'd70;
    localparam logic [CFG_W-1:0] DUTY_LOW_RST  = 8'd35;
    localparam logic [CFG_W-1:0] TRAILER_RST   = 8'd64;

    // request codes
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_HIGH = 2'd0,
        CFG_DUTY_LOW  = 2'd1,
        CFG_TRAILER   = 2'd2
    } t_cfg_idx;

    // registered item after the scaling stage
    typedef struct packed {
        logic                 valid;
        logic [1:0]           req;
        logic [LED_IDX_W-1:0] idx;
        logic                 more;
        logic [GRB_W-1:0]     grb;
    } t_item;

    // frame store write command
    typedef struct packed {
        logic                 we;
        logic                 clr;
        logic [LED_IDX_W-1:0] idx;
        logic [GRB_W-1:0]     data;
    } t_store_wr;

    // floor(x / 255) for the product of two 8-bit values, exact over that range
    function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + (PROD_W+1)'(x >> COLOR_W) + (PROD_W+1)'(1);
        return s[PROD_W-1:COLOR_W];
    endfunction

endpackage

[src/wfe_scale.sv]
module wfe_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_adv,
    input  logic [1:0]                    i_req,
    input  logic [wfe_pkg::LED_IDX_W-1:0] i_idx,
    input  logic [wfe_pkg::COLOR_W-1:0]   i_red,
    input  logic [wfe_pkg::COLOR_W-1:0]   i_green,
    input  logic [wfe_pkg::COLOR_W-1:0]   i_blue,
    input  logic [wfe_pkg::COLOR_W-1:0]   i_brightness,
    input  logic                          i_more,
    output wfe_pkg::t_item                o_item
);
    import wfe_pkg::*;

    logic                 r_valid;
    logic                 n_valid;
    logic [1:0]           r_req;
    logic [LED_IDX_W-1:0] r_idx;
    logic                 r_more;
    logic [PROD_W-1:0]    r_prod_r;
    logic [PROD_W-1:0]    r_prod_g;
    logic [PROD_W-1:0]    r_prod_b;

    // stage occupancy
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // capture word and brightness products
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req    <= i_req;
            r_idx    <= i_idx;
            r_more   <= i_more;
            r_prod_r <= i_red * i_brightness;
            r_prod_g <= i_green * i_brightness;
            r_prod_b <= i_blue * i_brightness;
        end
    end

    // divide by 255 and pack as grb
    always_comb begin
        o_item.valid = r_valid;
        o_item.req   = r_req;
        o_item.idx   = r_idx;
        o_item.more  = r_more;
        o_item.grb   = {div255(r_prod_g), div255(r_prod_r), div255(r_prod_b)};
    end

endmodule

[src/wfe_store.sv]
module wfe_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wfe_pkg::t_store_wr        i_wr,
    input  logic [wfe_pkg::PIX_W-1:0] i_rd_pix,
    output logic [wfe_pkg::GRB_W-1:0] o_rd_word
);
    import wfe_pkg::*;

    logic [GRB_W-1:0] r_store [STORE_DEPTH];
    logic             wr_ok;

    // writes beyond the last pixel are dropped
    assign wr_ok = i_wr.we && (i_wr.idx <= LED_IDX_W'(PIXELS));

    // reset and clear zero every pixel at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (wr_ok) begin
            r_store[PIX_W'(i_wr.idx)] <= i_wr.data;
        end
    end

    // live read for the slot sequencer, past the end reads zero
    assign o_rd_word = (i_rd_pix < PIX_W'(STORE_DEPTH)) ? r_store[i_rd_pix] : '0;

endmodule

[src/wfe_slot.sv]
module wfe_slot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wfe_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [wfe_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_tick,
    input  logic                          i_request,
    input  logic                          i_out_ready,
    output logic [wfe_pkg::PIX_W-1:0]     o_rd_pix,
    input  logic [wfe_pkg::GRB_W-1:0]     i_rd_word,
    output logic                          o_out_valid,
    output logic [wfe_pkg::CFG_W-1:0]     o_duty,
    output logic                          o_frame_end
);
    import wfe_pkg::*;

    logic [CFG_W-1:0] r_duty_high;
    logic [CFG_W-1:0] r_duty_low;
    logic [CFG_W-1:0] r_trailer;

    logic             r_sending, n_sending;
    logic             r_pending, n_pending;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [PIX_W-1:0] r_pix, n_pix;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_duty;
    logic             r_last;

    logic             emit;
    logic             in_pixels;
    logic             last;
    logic [CFG_W-1:0] slot_duty;
    logic [POS_W:0]   total;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_high <= DUTY_HIGH_RST;
            r_duty_low  <= DUTY_LOW_RST;
            r_trailer   <= TRAILER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DUTY_HIGH: r_duty_high <= i_cfg_data;
                CFG_DUTY_LOW:  r_duty_low  <= i_cfg_data;
                CFG_TRAILER:   r_trailer   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // slot decode, counters sit at slot 0 whenever idle
    assign o_rd_pix  = r_pix;
    assign emit      = i_tick && (r_sending || r_pending);
    assign in_pixels = r_pos < POS_W'(PIXEL_SLOTS);
    assign total     = (POS_W+1)'(PIXEL_SLOTS) + (POS_W+1)'(r_trailer);
    assign last      = ({1'b0, r_pos} + (POS_W+1)'(1)) >= total;
    assign slot_duty = !in_pixels ? '0 : (i_rd_word[r_bit] ? r_duty_high : r_duty_low);

    // frame sequencing, a request seen during a frame waits for its end
    always_comb begin
        n_sending   = r_sending;
        n_pending   = r_pending;
        n_pos       = r_pos;
        n_pix       = r_pix;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_request) begin
            n_pending = 1'b1;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            if (!r_sending) begin
                n_sending = 1'b1;
                n_pending = 1'b0;
            end
            if (last) begin
                n_sending = 1'b0;
                n_pos     = '0;
                n_pix     = '0;
                n_bit     = BIT_W'(BITS_PER_PIXEL - 1);
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (r_bit == '0) begin
                    n_bit = BIT_W'(BITS_PER_PIXEL - 1);
                    if (r_pix < PIX_W'(STORE_DEPTH)) begin
                        n_pix = r_pix + PIX_W'(1);
                    end
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_pending   <= 1'b0;
            r_pos       <= '0;
            r_pix       <= '0;
            r_bit       <= BIT_W'(BITS_PER_PIXEL - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_sending   <= n_sending;
            r_pending   <= n_pending;
            r_pos       <= n_pos;
            r_pix       <= n_pix;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_duty <= slot_duty;
            r_last <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_duty;
    assign o_frame_end = r_last;

endmodule

[src/ws2812_frame_encoder.sv]
// WS2812 frame encoder: keeps a 17-pixel GRB frame store and turns it into one PWM
// duty value per bit slot. Input words are pixel writes (colour scaled by brightness
// as floor(c*b/255)), whole-frame clears, or ticks; a write or clear without
// more_follows requests a frame, and the next tick that finds the block idle starts
// it. Each tick of a running frame yields one output word: 408 data slots MSB first
// (duty_high for a one, duty_low for a zero), then trailer_slots zero slots, with
// tlast on the final slot. One word is accepted per clock unless a tick stalls; an
// accepted word is captured in the input/product register, from where it acts on
// the store and frame logic, and a tick loads the result register that holds its
// output word. A tick stalls only while the output register holds a word that has
// not been taken. The user must write registers through the cfg port only while
// the block is idle; the block itself does not enforce this.
module ws2812_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // input words
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // led_index, red, green, blue, brightness, zero pad
    input  logic [2:0]  i_s_axis_tuser,  // req_type, more_follows
    // output words
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // duty
    output logic        o_m_axis_tlast
);
    import wfe_pkg::*;

    t_item      item;
    t_store_wr  store_wr;
    logic       load;
    logic       adv;
    logic       out_free;
    logic       is_tick;
    logic [PIX_W-1:0] rd_pix;
    logic [GRB_W-1:0] rd_word;

    // handshake: a tick waits for room in the result register
    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;
    assign is_tick         = item.req == REQ_TICK;
    assign adv             = item.valid && (!is_tick || out_free);
    assign o_s_axis_tready = !item.valid || adv;
    assign load            = i_s_axis_tvalid && o_s_axis_tready;

    wfe_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_adv        (adv),
        .i_req        (i_s_axis_tuser[1:0]),
        .i_idx        (i_s_axis_tdata[4:0]),
        .i_red        (i_s_axis_tdata[12:5]),
        .i_green      (i_s_axis_tdata[20:13]),
        .i_blue       (i_s_axis_tdata[28:21]),
        .i_brightness (i_s_axis_tdata[36:29]),
        .i_more       (i_s_axis_tuser[2]),
        .o_item       (item)
    );

    // store command from the word in the frame stage
    always_comb begin
        store_wr.we   = adv && (item.req == REQ_WRITE);
        store_wr.clr  = adv && (item.req == REQ_CLEAR);
        store_wr.idx  = item.idx;
        store_wr.data = item.grb;
    end

    wfe_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_pix  (rd_pix),
        .o_rd_word (rd_word)
    );

    wfe_slot u_slot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (adv && is_tick),
        .i_request   ((store_wr.we || store_wr.clr) && !item.more),
        .i_out_ready (i_m_axis_tready),
        .o_rd_pix    (rd_pix),
        .i_rd_word   (rd_word),
        .o_out_valid (o_m_axis_tvalid),
        .o_duty      (o_m_axis_tdata),
        .o_frame_end (o_m_axis_tlast)
    );

endmodule

[src/wfe_port_check.sv]
module wfe_port_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    // input back-pressure only comes from a stalled output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a stalled output word");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind ws2812_frame_encoder wfe_port_check u_port_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
